@@ rtl/mlfd_pkg.sv @@
package mlfd_pkg;

	localparam int unsigned PAYLOAD_MAX_DEF = 256;

	localparam logic [7:0] MAGIC_FIRST   = 8'hA5;
	localparam logic [7:0] MAGIC_SECOND  = 8'h5A;
	localparam logic [7:0] FRAME_VERSION = 8'h01;

	localparam int unsigned LEN_OUT_W = 9;
	localparam int unsigned TDATA_OUT_W = 32;

	typedef enum logic [6:0] {
		PH_HUNT    = 7'b0000001,
		PH_MAGIC0  = 7'b0000010,
		PH_MAGIC1  = 7'b0000100,
		PH_VERSION = 7'b0001000,
		PH_TYPE    = 7'b0010000,
		PH_LENHI   = 7'b0100000,
		PH_PAYLOAD = 7'b1000000
	} phase_t;

	// A failing byte that is itself a first magic byte starts a new header.
	function automatic phase_t resync_phase(input logic [7:0] b);
		return (b == MAGIC_FIRST) ? PH_MAGIC0 : PH_HUNT;
	endfunction

endpackage

@@ rtl/magic_length_frame_deframer.sv @@
// An accepted input item that yields a result shows it on the m_ side in the cycle after it is accepted.
// Throughput: one input item per cycle; the byte parser and the result register
// take a new item whenever the result register is empty or being drained.
// Reset: arst_n clears the parser to hunting for the first magic byte, clears
// the held type, length, byte count and discard flag, and empties the result.
module magic_length_frame_deframer #(
	parameter int unsigned PAYLOAD_MAX = mlfd_pkg::PAYLOAD_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // chunk_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] frame_type, [16:8] frame_length,
	                               // [24:17] payload_byte, [31:25] zero
	output logic [0:0]  m_tuser,   // [0] has_data
	output logic        m_tlast    // frame_last
);

	localparam int unsigned CNT_W = (PAYLOAD_MAX < 2) ? 1 : $clog2(PAYLOAD_MAX + 1);
	localparam logic [15:0] LEN_LIMIT = 16'(PAYLOAD_MAX);

	mlfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]       type_q, type_d;
	logic [15:0]      len_q, len_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic             discard_q, discard_d;

	logic             acc;
	logic             emit, emit_data, emit_last;
	logic [7:0]       emit_byte;
	logic [15:0]      len_full;

	logic             out_valid_q;
	logic [7:0]       out_type_q;
	logic [mlfd_pkg::LEN_OUT_W-1:0] out_len_q;
	logic [7:0]       out_byte_q;
	logic             out_data_q;
	logic             out_last_q;

	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign len_full = {len_q[15:8], s_tdata};

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		len_d     = len_q;
		left_d    = left_q;
		discard_d = discard_q;
		emit      = 1'b0;
		emit_data = 1'b0;
		emit_last = 1'b0;
		emit_byte = '0;
		if (discard_q) begin
			// drop bytes up to and including the chunk end
			if (s_tlast) begin
				discard_d = 1'b0;
			end
		end else begin
			case (phase_q)
				mlfd_pkg::PH_MAGIC0: begin
					phase_d = (s_tdata == mlfd_pkg::MAGIC_SECOND) ? mlfd_pkg::PH_MAGIC1
						: mlfd_pkg::resync_phase(s_tdata);
				end
				mlfd_pkg::PH_MAGIC1: begin
					phase_d = (s_tdata == mlfd_pkg::FRAME_VERSION) ? mlfd_pkg::PH_VERSION
						: mlfd_pkg::resync_phase(s_tdata);
				end
				mlfd_pkg::PH_VERSION: begin
					type_d  = s_tdata;
					phase_d = mlfd_pkg::PH_TYPE;
				end
				mlfd_pkg::PH_TYPE: begin
					len_d   = {s_tdata, 8'h00};
					phase_d = mlfd_pkg::PH_LENHI;
				end
				mlfd_pkg::PH_LENHI: begin
					len_d = len_full;
					if (len_full > LEN_LIMIT) begin
						phase_d   = mlfd_pkg::PH_HUNT;
						discard_d = !s_tlast;
					end else if (len_full == 16'h0000) begin
						phase_d   = mlfd_pkg::PH_HUNT;
						emit      = 1'b1;
						emit_last = 1'b1;
					end else begin
						left_d  = len_full[CNT_W-1:0];
						phase_d = mlfd_pkg::PH_PAYLOAD;
					end
				end
				mlfd_pkg::PH_PAYLOAD: begin
					emit      = 1'b1;
					emit_data = 1'b1;
					emit_byte = s_tdata;
					emit_last = (left_q <= CNT_W'(1));
					if (left_q != '0) begin
						left_d = left_q - CNT_W'(1);
					end
					if (emit_last) begin
						phase_d = mlfd_pkg::PH_HUNT;
					end
				end
				default: begin
					phase_d = mlfd_pkg::resync_phase(s_tdata);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mlfd_pkg::PH_HUNT;
			type_q    <= '0;
			len_q     <= '0;
			left_q    <= '0;
			discard_q <= 1'b0;
		end else if (acc) begin
			phase_q   <= phase_d;
			type_q    <= type_d;
			len_q     <= len_d;
			left_q    <= left_d;
			discard_q <= discard_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_type_q <= type_d;
			out_len_q  <= len_d[mlfd_pkg::LEN_OUT_W-1:0];
			out_byte_q <= emit_byte;
			out_data_q <= emit_data;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {7'b0000000, out_byte_q, out_len_q, out_type_q};
	assign m_tuser[0] = out_data_q;
	assign m_tlast    = out_last_q;

endmodule

@@ rtl/mlfd_checker.sv @@
module mlfd_checker #(
	parameter int unsigned PAYLOAD_MAX = mlfd_pkg::PAYLOAD_MAX_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result is stalled");

	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without an accepted item");

	a_empty_notice: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[24:17] == 8'h00))
		else $error("empty frame notice malformed");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (PAYLOAD_MAX > 511) || (m_tdata[16:8] != 9'd0))
		else $error("payload byte with zero frame length");

endmodule

bind magic_length_frame_deframer mlfd_checker #(.PAYLOAD_MAX(PAYLOAD_MAX)) u_mlfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
